@@ sv/pj128_pkg.sv @@
package pj128_pkg;

	localparam int unsigned ROUNDS_DEFAULT = 14;

	typedef logic [31:0]  word_t;
	typedef logic [127:0] block_t;

	typedef enum logic {
		REG_KEY_HI = 1'b0,
		REG_KEY_LO = 1'b1
	} reg_idx_t;

	localparam word_t MAT_ROW0 = 32'ha3861085;
	localparam word_t MAT_ROW1 = 32'h63417021;
	localparam word_t MAT_ROW2 = 32'h692cf280;
	localparam word_t MAT_ROW3 = 32'h48a54813;
	localparam word_t MAT_KEY  = 32'hb881b9ca;
	localparam word_t KC0      = 32'h00000080;
	localparam word_t KC1      = 32'h00006a00;
	localparam word_t KC2      = 32'h003f0000;
	localparam word_t KC3      = 32'h24000000;

	// Circulant matrix times vector; vector bit 31 selects the first column.
	function automatic word_t circ_mul(input word_t col, input word_t vec);
		word_t acc;
		word_t c;
		acc = '0;
		c   = col;
		for (int b = 31; b >= 0; b--) begin
			if (vec[b]) begin
				acc = acc ^ c;
			end
			c = {c[0], c[31:1]};
		end
		return acc;
	endfunction

	// Bitsliced 4-bit S-box; row 0 sits in the top word.
	function automatic block_t sbox_layer(input block_t s);
		word_t s0;
		word_t s1;
		word_t s2;
		word_t s3;
		s0 = s[127:96];
		s1 = s[95:64];
		s2 = s[63:32];
		s3 = s[31:0];
		s0 = s0 ^ s3;
		s3 = s3 ^ (s0 & s1);
		s0 = s0 ^ (s1 & s2);
		s1 = s1 ^ (s2 & s3);
		s2 = s2 ^ (s0 & s3);
		s2 = s2 ^ s1;
		s1 = s1 ^ s0;
		s3 = ~s3;
		return {s0, s1, s3, s2};
	endfunction

	// One step of the key schedule; rc is the index of the step.
	function automatic block_t key_step(input block_t k, input word_t rc);
		word_t mix;
		word_t p0;
		word_t p1;
		word_t p2;
		word_t p3;
		mix = k[127:96] ^ k[95:64] ^ k[63:32] ^ k[31:0];
		p0  = k[127:96] ^ mix;
		p1  = k[95:64] ^ mix;
		p2  = k[63:32] ^ mix;
		p3  = k[31:0] ^ mix;
		return {circ_mul(MAT_KEY, p0) ^ KC0 ^ rc,
			{p1[7:0], p1[31:8]} ^ KC1,
			{p2[14:0], p2[31:15]} ^ KC2,
			{p3[17:0], p3[31:18]} ^ KC3};
	endfunction

endpackage

@@ sv/pyjamask128_encrypt_unit.sv @@
// One item per cycle is taken while the output is not stalled; each round and
// its key schedule step is one pipeline stage, after a first stage that adds
// the whitening key. A stalled output holds its stage, and free stages
// upstream still fill. Reset (arst_n low, asynchronous) clears all stage valid
// bits and both key registers.
module pyjamask128_encrypt_unit #(
	parameter int unsigned ROUNDS = pj128_pkg::ROUNDS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  pj128_pkg::reg_idx_t cfg_idx,
	input  logic [63:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [63:0]         block_hi,
	input  logic [63:0]         block_lo,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         cipher_hi,
	output logic [63:0]         cipher_lo
);
	import pj128_pkg::*;

	logic [63:0] key_hi_q;
	logic [63:0] key_lo_q;

	logic   [ROUNDS:0] valid_s;
	logic   [ROUNDS:0] adv;
	block_t            state_s [ROUNDS+1];
	block_t            key_s   [ROUNDS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KEY_HI: key_hi_q <= cfg_data;
				REG_KEY_LO: key_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv[ROUNDS] = !valid_s[ROUNDS] || out_ready;
	assign adv[0]      = !valid_s[0] || adv[1];
	assign in_ready    = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv[0]) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0] && in_valid) begin
			state_s[0] <= {block_hi, block_lo} ^ {key_hi_q, key_lo_q};
			key_s[0]   <= {key_hi_q, key_lo_q};
		end
	end

	for (genvar k = 1; k <= ROUNDS; k++) begin : g_round
		block_t state_nxt;
		block_t key_nxt;

		if (k < ROUNDS) begin : g_adv
			assign adv[k] = !valid_s[k] || adv[k+1];
		end

		pj128_round u_round (
			.state     (state_s[k-1]),
			.key       (key_s[k-1]),
			.rc        (32'(k - 1)),
			.state_nxt (state_nxt),
			.key_nxt   (key_nxt)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv[k]) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && valid_s[k-1]) begin
				state_s[k] <= state_nxt;
				key_s[k]   <= key_nxt;
			end
		end
	end

	assign out_valid = valid_s[ROUNDS];
	assign cipher_hi = state_s[ROUNDS][127:64];
	assign cipher_lo = state_s[ROUNDS][63:0];

endmodule

@@ sv/pj128_round.sv @@
module pj128_round (
	input  pj128_pkg::block_t state,
	input  pj128_pkg::block_t key,
	input  pj128_pkg::word_t  rc,
	output pj128_pkg::block_t state_nxt,
	output pj128_pkg::block_t key_nxt
);
	import pj128_pkg::*;

	block_t sb;
	block_t mixed;

	always_comb begin
		sb    = sbox_layer(state);
		mixed = {circ_mul(MAT_ROW0, sb[127:96]),
			circ_mul(MAT_ROW1, sb[95:64]),
			circ_mul(MAT_ROW2, sb[63:32]),
			circ_mul(MAT_ROW3, sb[31:0])};
	end

	assign key_nxt   = key_step(key, rc);
	assign state_nxt = mixed ^ key_nxt;

endmodule

@@ sv/pj128_checker.sv @@
module pj128_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [63:0]         block_hi,
	input logic [63:0]         block_lo,
	input logic                out_valid,
	input logic                out_ready,
	input logic [63:0]         cipher_hi,
	input logic [63:0]         cipher_lo
);

	// A result that is not taken stays on the output unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_hi) && $stable(cipher_lo))
		else $error("output item changed while stalled");

	// An input item that waits stays offered unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(block_hi) && $stable(block_lo))
		else $error("input item changed while waiting");

	// The pipeline only pushes back when its last stage is full and blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked output");

	// When the output can move, every stage can move.
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ready || !out_valid) |-> in_ready)
		else $error("input stalled while the output is free");

	// Leaving reset, no result is shown.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind pyjamask128_encrypt_unit pj128_checker u_pj128_checker (.*);
